// File: design/m68k_ea_pkg.sv
// Package for the 68000 effective-address sequencer.
// Holds opcodes, step codes, access kinds and the step-list table.
// No dependencies.
package m68k_ea_pkg;

    typedef enum logic [2:0] {
        OP_STEP      = 3'd0,
        OP_BEGIN_RD  = 3'd1,
        OP_BEGIN_MOD = 3'd2,
        OP_WRITE_REG = 3'd3,
        OP_READ_REG  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_READ  = 3'd1,
        ST_WRITE = 3'd2,
        ST_FETCH = 3'd3,
        ST_ABS   = 3'd4,
        ST_SDISP = 3'd5,
        ST_INDEX = 3'd6
    } step_t;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_RD_WORD = 3'd1;
    localparam logic [2:0] KIND_RD_BYTE = 3'd2;
    localparam logic [2:0] KIND_FETCH   = 3'd3;
    localparam logic [2:0] KIND_WR_WORD = 3'd4;
    localparam logic [2:0] KIND_WR_BYTE = 3'd5;

    localparam int unsigned DataWidth = 32;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] op_word;
        logic [31:0] value_in;
        logic [4:0]  register_select;
        logic [15:0] bus_data;
        logic [1:0]  extra_data_word;
        logic [1:0]  extra_data_long;
        logic [1:0]  extra_addr_word;
        logic [1:0]  extra_addr_long;
    } ea_in_t;

    typedef struct packed {
        logic        done_res;
        logic [31:0] operand;
        logic [2:0]  access_kind;
        logic [31:0] access_address;
        logic [15:0] write_data;
        logic [2:0]  next_kind;
        logic [31:0] next_address;
        logic [31:0] register_value;
    } ea_out_t;

    function automatic step_t step_at(input logic [2:0] list, input logic [2:0] idx);
        step_t s;
        s = ST_NONE;
        unique case (list)
            3'd0: if (idx == 3'd0 || idx == 3'd2) s = ST_READ;
            3'd1: if (idx == 3'd1 || idx == 3'd3) s = ST_READ;
            3'd2:
            begin
                if (idx == 3'd0) s = ST_FETCH;
                else if (idx == 3'd1) s = ST_SDISP;
                else if (idx == 3'd2 || idx == 3'd4) s = ST_READ;
            end
            3'd3:
            begin
                if (idx == 3'd1) s = ST_FETCH;
                else if (idx == 3'd2) s = ST_INDEX;
                else if (idx == 3'd3 || idx == 3'd5) s = ST_READ;
            end
            3'd4:
            begin
                if (idx == 3'd0 || idx == 3'd2) s = ST_FETCH;
                else if (idx == 3'd3) s = ST_ABS;
                else if (idx == 3'd4 || idx == 3'd6) s = ST_READ;
            end
            3'd5: if (idx == 3'd0 || idx == 3'd2) s = ST_FETCH;
            3'd6: s = ST_NONE;
            default: if (idx == 3'd0 || idx == 3'd2) s = ST_WRITE;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] sx8(input logic [31:0] x);
        return {{24{x[7]}}, x[7:0]};
    endfunction

    function automatic logic [31:0] sx16(input logic [31:0] x);
        return {{16{x[15]}}, x[15:0]};
    endfunction

endpackage

// File: design/m68k_ea_stream_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; payload type is given at instantiation.
interface m68k_ea_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/m68000_effective_address_sequencer_core.sv
// The result of an accepted transfer is loaded into the result register at the accepting edge
// and is offered on the output from that register.
// Throughput: one item per cycle unless the output stalls; the whole micro-step is one pass of
// combinational logic from the input channel and architectural state into the result register.
// A stalled output holds; input is taken whenever the output register is free or draining.
// Reset (rst_n low, async): registers D0-D7, A0-A7, PC, EA, gathered data clear, size mask
// all ones, sequencer idle.
module m68000_effective_address_sequencer_core (
    input  logic clk,
    input  logic rst_n,
    m68k_ea_stream_if.sink   in_ch,
    m68k_ea_stream_if.source out_ch
);

    // Architectural state.
    logic [31:0] d_reg [8];
    logic [31:0] a_reg [8];
    logic [31:0] pc_reg, ea_reg, gd_reg, mask_reg;
    logic        rd_byte_reg, wr_byte_reg;
    logic [2:0]  list_reg, idx_reg;
    logic [3:0]  left_reg;

    logic [31:0] d_next [8];
    logic [31:0] a_next [8];
    logic [31:0] pc_next, ea_next, gd_next, mask_next;
    logic        rd_byte_next, wr_byte_next;
    logic [2:0]  list_next, idx_next;
    logic [3:0]  left_next;

    m68k_ea_pkg::ea_out_t res_reg, res_next;
    logic                 out_valid_reg;

    logic take;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign take         = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    m68k_ea_pkg::ea_in_t i;
    assign i = in_ch.data;

    always_comb
    begin
        logic [2:0]  reg_n, sz;
        logic [5:0]  mode;
        logic [31:0] size, off, lc;
        logic [3:0]  xtra;
        m68k_ea_pkg::step_t st;
        d_next = d_reg; a_next = a_reg;
        pc_next = pc_reg; ea_next = ea_reg; gd_next = gd_reg; mask_next = mask_reg;
        rd_byte_next = rd_byte_reg; wr_byte_next = wr_byte_reg;
        list_next = list_reg; idx_next = idx_reg; left_next = left_reg;
        res_next = '0;
        reg_n = i.op_word[2:0];
        sz    = {1'b0, i.op_word[7:6]};
        mode  = i.op_word[5:0];
        if (mode < 6'h38) mode = mode & 6'h38;
        size = 32'd0; lc = 32'd0; off = 32'd0; xtra = 4'd0;
        st = m68k_ea_pkg::step_at(list_reg, idx_reg);
        unique case (i.opcode)
            m68k_ea_pkg::OP_STEP:
            begin
                if (left_reg == 4'd0)
                begin
                    res_next.done_res = 1'b1;
                    res_next.operand  = gd_reg & mask_reg;
                end
                else
                begin
                    unique case (st)
                        m68k_ea_pkg::ST_READ:
                        begin
                            res_next.access_kind = rd_byte_reg ? m68k_ea_pkg::KIND_RD_BYTE
                                                               : m68k_ea_pkg::KIND_RD_WORD;
                            res_next.access_address = ea_reg;
                            gd_next = {gd_reg[15:0], 16'd0} +
                                      (rd_byte_reg ? {24'd0, i.bus_data[7:0]}
                                                   : {16'd0, i.bus_data});
                            ea_next = ea_reg + 32'd2;
                        end
                        m68k_ea_pkg::ST_WRITE:
                        begin
                            ea_next = ea_reg - 32'd2;
                            res_next.access_kind = wr_byte_reg ? m68k_ea_pkg::KIND_WR_BYTE
                                                               : m68k_ea_pkg::KIND_WR_WORD;
                            res_next.access_address = ea_next;
                            res_next.write_data = wr_byte_reg ? {8'd0, gd_reg[7:0]}
                                                              : gd_reg[15:0];
                            gd_next = {16'd0, gd_reg[31:16]};
                        end
                        m68k_ea_pkg::ST_FETCH:
                        begin
                            res_next.access_kind    = m68k_ea_pkg::KIND_FETCH;
                            res_next.access_address = pc_reg;
                            gd_next = {gd_reg[15:0], i.bus_data};
                            pc_next = pc_reg + 32'd2;
                        end
                        m68k_ea_pkg::ST_ABS:   ea_next = gd_reg;
                        m68k_ea_pkg::ST_SDISP: ea_next = ea_reg + m68k_ea_pkg::sx16(gd_reg);
                        m68k_ea_pkg::ST_INDEX:
                        begin
                            off = gd_reg[15] ? a_reg[gd_reg[14:12]] : d_reg[gd_reg[14:12]];
                            if (!gd_reg[11]) off = m68k_ea_pkg::sx16(off);
                            ea_next = ea_reg + m68k_ea_pkg::sx8(gd_reg) + off;
                        end
                        default: ;
                    endcase
                    left_next = left_reg - 4'd1;
                    idx_next  = idx_reg + 3'd1;
                end
            end
            m68k_ea_pkg::OP_BEGIN_RD:
            begin
                gd_next = '0; mask_next = '1; rd_byte_next = 1'b0;
                unique case (i.op_word[7:6])
                    2'd0:
                    begin
                        size = (reg_n == 3'd7) ? 32'd2 : 32'd1;
                        mask_next = 32'hff; rd_byte_next = 1'b1;
                    end
                    2'd1: begin size = 32'd2; mask_next = 32'hffff; end
                    2'd2: begin size = 32'd4; lc = 32'd2; end
                    default: ;
                endcase
                list_next = 3'd0; idx_next = 3'd0; left_next = 4'd0;
                unique case (mode)
                    6'h00: gd_next = d_reg[reg_n];
                    6'h08: gd_next = a_reg[reg_n];
                    6'h10: begin ea_next = a_reg[reg_n]; left_next = 4'(2 + lc); end
                    6'h18:
                    begin
                        ea_next = a_reg[reg_n];
                        a_next[reg_n] = a_reg[reg_n] + size;
                        left_next = 4'(2 + lc);
                    end
                    6'h20:
                    begin
                        a_next[reg_n] = a_reg[reg_n] - size;
                        ea_next = a_next[reg_n];
                        list_next = 3'd1; left_next = 4'(3 + lc);
                    end
                    6'h28:
                    begin
                        ea_next = a_reg[reg_n]; list_next = 3'd2; left_next = 4'(4 + lc);
                    end
                    6'h30:
                    begin
                        ea_next = a_reg[reg_n]; list_next = 3'd3; left_next = 4'(5 + lc);
                    end
                    6'h38: begin ea_next = '0; list_next = 3'd2; left_next = 4'(4 + lc); end
                    6'h39: begin list_next = 3'd4; left_next = 4'(6 + lc); end
                    6'h3A: begin ea_next = pc_reg; list_next = 3'd2; left_next = 4'(4 + lc); end
                    6'h3B: begin ea_next = pc_reg; list_next = 3'd3; left_next = 4'(5 + lc); end
                    6'h3C: begin list_next = 3'd5; left_next = 4'(2 + lc); end
                    default: ;
                endcase
            end
            m68k_ea_pkg::OP_BEGIN_MOD:
            begin
                gd_next = '0;
                wr_byte_next = (sz == 3'd0);
                list_next = 3'd0; idx_next = 3'd0; left_next = 4'd0;
                unique case (mode)
                    6'h00:
                    begin
                        if (sz == 3'd0)
                            d_next[reg_n] = {d_reg[reg_n][31:8], i.value_in[7:0]};
                        else if (sz == 3'd1)
                            d_next[reg_n] = {d_reg[reg_n][31:16], i.value_in[15:0]};
                        else if (sz == 3'd2)
                            d_next[reg_n] = i.value_in;
                        xtra = {2'd0, (sz == 3'd2) ? i.extra_data_long : i.extra_data_word};
                        list_next = 3'd6; left_next = xtra;
                    end
                    6'h08:
                    begin
                        if (sz == 3'd1) a_next[reg_n] = m68k_ea_pkg::sx16(i.value_in);
                        else if (sz == 3'd2) a_next[reg_n] = i.value_in;
                        xtra = {2'd0, (sz == 3'd2) ? i.extra_addr_long : i.extra_addr_word};
                        list_next = 3'd6; left_next = xtra;
                    end
                    6'h10, 6'h18, 6'h20, 6'h28, 6'h30, 6'h38, 6'h39, 6'h3A, 6'h3B:
                    begin
                        gd_next = i.value_in;
                        list_next = 3'd7; left_next = (sz == 3'd2) ? 4'd4 : 4'd2;
                    end
                    default: ;
                endcase
            end
            m68k_ea_pkg::OP_WRITE_REG:
            begin
                if (i.register_select < 5'd8) d_next[i.register_select[2:0]] = i.value_in;
                else if (i.register_select < 5'd16) a_next[i.register_select[2:0]] = i.value_in;
                else if (i.register_select == 5'd16) pc_next = i.value_in;
            end
            m68k_ea_pkg::OP_READ_REG:
            begin
                if (i.register_select < 5'd8)
                    res_next.register_value = d_reg[i.register_select[2:0]];
                else if (i.register_select < 5'd16)
                    res_next.register_value = a_reg[i.register_select[2:0]];
                else if (i.register_select == 5'd16)
                    res_next.register_value = pc_reg;
            end
            default: ;
        endcase
        // Announce the access of the following step from the updated state.
        if (left_next != 4'd0)
        begin
            unique case (m68k_ea_pkg::step_at(list_next, idx_next))
                m68k_ea_pkg::ST_READ:
                begin
                    res_next.next_kind = rd_byte_next ? m68k_ea_pkg::KIND_RD_BYTE
                                                      : m68k_ea_pkg::KIND_RD_WORD;
                    res_next.next_address = ea_next;
                end
                m68k_ea_pkg::ST_WRITE:
                begin
                    res_next.next_kind = wr_byte_next ? m68k_ea_pkg::KIND_WR_BYTE
                                                      : m68k_ea_pkg::KIND_WR_WORD;
                    res_next.next_address = ea_next - 32'd2;
                end
                m68k_ea_pkg::ST_FETCH:
                begin
                    res_next.next_kind = m68k_ea_pkg::KIND_FETCH;
                    res_next.next_address = pc_next;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                d_reg[k] <= '0;
                a_reg[k] <= '0;
            end
            pc_reg <= '0; ea_reg <= '0; gd_reg <= '0; mask_reg <= '1;
            rd_byte_reg <= 1'b0; wr_byte_reg <= 1'b0;
            list_reg <= '0; idx_reg <= '0; left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                d_reg <= d_next; a_reg <= a_next;
                pc_reg <= pc_next; ea_reg <= ea_next; gd_reg <= gd_next;
                mask_reg <= mask_next;
                rd_byte_reg <= rd_byte_next; wr_byte_reg <= wr_byte_next;
                list_reg <= list_next; idx_reg <= idx_next; left_reg <= left_next;
            end
            if (in_ch.ready) out_valid_reg <= take;
        end
    end

    // Result payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (take) res_reg <= res_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(res_reg))
        else $error("result dropped under stall");
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && i.opcode == m68k_ea_pkg::OP_STEP && left_reg == 4'd0 |=> res_reg.done_res)
        else $error("idle step did not report done");
    a_no_stall_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(left_reg) && $stable(pc_reg))
        else $error("state moved without a transfer");

endmodule

// File: bench/tb_m68000_effective_address_sequencer_core.sv
// Testbench for the 68000 effective-address sequencer core: random and directed items
// checked against an in-bench operand-sequence predictor through a small scoreboard.
// Depends on m68k_ea_pkg, m68k_ea_stream_if and the core itself.
`timescale 1ns / 100ps

import m68k_ea_pkg::*;

class ea_scoreboard;
    logic [31:0] dreg [8];
    logic [31:0] areg [8];
    logic [31:0] pc;
    logic [31:0] ea;
    logic [31:0] gathered;
    logic [31:0] mask;
    logic        rd_byte;
    logic        wr_byte;
    logic [2:0]  list_no;
    logic [2:0]  list_pos;
    logic [3:0]  left;
    step_t       plan [8][8];
    ea_out_t     pending [$];
    int          errors;

    function new();
        plan[0] = '{ST_READ, ST_NONE, ST_READ, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE};
        plan[1] = '{ST_NONE, ST_READ, ST_NONE, ST_READ, ST_NONE, ST_NONE, ST_NONE, ST_NONE};
        plan[2] = '{ST_FETCH, ST_SDISP, ST_READ, ST_NONE, ST_READ, ST_NONE, ST_NONE, ST_NONE};
        plan[3] = '{ST_NONE, ST_FETCH, ST_INDEX, ST_READ, ST_NONE, ST_READ, ST_NONE, ST_NONE};
        plan[4] = '{ST_FETCH, ST_NONE, ST_FETCH, ST_ABS, ST_READ, ST_NONE, ST_READ, ST_NONE};
        plan[5] = '{ST_FETCH, ST_NONE, ST_FETCH, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE};
        plan[6] = '{ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE};
        plan[7] = '{ST_WRITE, ST_NONE, ST_WRITE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE};
        foreach (dreg[i])
        begin
            dreg[i] = '0;
            areg[i] = '0;
        end
        pc = '0;
        ea = '0;
        gathered = '0;
        mask = '1;
        rd_byte = 1'b0;
        wr_byte = 1'b0;
        list_no = '0;
        list_pos = '0;
        left = '0;
        errors = 0;
    endfunction

    function void load_list(input int l, input int n);
        list_no = 3'(l);
        list_pos = '0;
        left = 4'(n);
    endfunction

    function void start_read(input logic [15:0] op);
        logic [2:0]  r;
        logic [5:0]  mode;
        logic [31:0] sz;
        logic [3:0]  lc;
        r = op[2:0];
        mode = op[5:0];
        sz = '0;
        lc = '0;
        gathered = '0;
        mask = '1;
        rd_byte = 1'b0;
        case (op[7:6])
            2'd0:
            begin
                sz = (r == 3'd7) ? 32'd2 : 32'd1;
                mask = 32'hff;
                rd_byte = 1'b1;
            end
            2'd1:
            begin
                sz = 32'd2;
                mask = 32'hffff;
            end
            2'd2:
            begin
                sz = 32'd4;
                lc = 4'd2;
            end
            default: ;
        endcase
        if (mode < 6'h38)
            mode &= 6'h38;
        load_list(0, 0);
        case (mode)
            6'h00: gathered = dreg[r];
            6'h08: gathered = areg[r];
            6'h10:
            begin
                ea = areg[r];
                load_list(0, 2 + lc);
            end
            6'h18:
            begin
                ea = areg[r];
                areg[r] += sz;
                load_list(0, 2 + lc);
            end
            6'h20:
            begin
                areg[r] -= sz;
                ea = areg[r];
                load_list(1, 3 + lc);
            end
            6'h28:
            begin
                ea = areg[r];
                load_list(2, 4 + lc);
            end
            6'h30:
            begin
                ea = areg[r];
                load_list(3, 5 + lc);
            end
            6'h38:
            begin
                ea = '0;
                load_list(2, 4 + lc);
            end
            6'h39: load_list(4, 6 + lc);
            6'h3A:
            begin
                ea = pc;
                load_list(2, 4 + lc);
            end
            6'h3B:
            begin
                ea = pc;
                load_list(3, 5 + lc);
            end
            6'h3C: load_list(5, 2 + lc);
            default: ;
        endcase
    endfunction

    function void start_modify(input ea_in_t x);
        logic [2:0] r;
        logic [5:0] mode;
        logic [1:0] sz;
        r = x.op_word[2:0];
        mode = x.op_word[5:0];
        sz = x.op_word[7:6];
        gathered = '0;
        wr_byte = (sz == 2'd0);
        if (mode < 6'h38)
            mode &= 6'h38;
        load_list(0, 0);
        if (mode == 6'h00)
        begin
            if (sz == 2'd0)
                dreg[r] = {dreg[r][31:8], x.value_in[7:0]};
            else if (sz == 2'd1)
                dreg[r] = {dreg[r][31:16], x.value_in[15:0]};
            else if (sz == 2'd2)
                dreg[r] = x.value_in;
            load_list(6, int'((sz == 2'd2) ? x.extra_data_long : x.extra_data_word));
        end
        else if (mode == 6'h08)
        begin
            if (sz == 2'd1)
                areg[r] = {{16{x.value_in[15]}}, x.value_in[15:0]};
            else if (sz == 2'd2)
                areg[r] = x.value_in;
            load_list(6, int'((sz == 2'd2) ? x.extra_addr_long : x.extra_addr_word));
        end
        else if (mode <= 6'h3B)
        begin
            gathered = x.value_in;
            load_list(7, (sz == 2'd2) ? 4 : 2);
        end
    endfunction

    // Work out the result of one accepted item and advance the local state.
    function ea_out_t predict_step(input ea_in_t x);
        ea_out_t     y;
        step_t       s;
        logic [31:0] off;
        logic [2:0]  ri;
        y = '0;
        case (x.opcode)
            OP_STEP:
            begin
                if (left == 0)
                begin
                    y.done_res = 1'b1;
                    y.operand = gathered & mask;
                end
                else
                begin
                    s = plan[list_no][list_pos];
                    case (s)
                        ST_READ:
                        begin
                            y.access_kind = rd_byte ? KIND_RD_BYTE : KIND_RD_WORD;
                            y.access_address = ea;
                            gathered = (gathered << 16)
                                + (rd_byte ? {24'd0, x.bus_data[7:0]} : {16'd0, x.bus_data});
                            ea += 2;
                        end
                        ST_WRITE:
                        begin
                            ea -= 2;
                            y.access_kind = wr_byte ? KIND_WR_BYTE : KIND_WR_WORD;
                            y.access_address = ea;
                            y.write_data = wr_byte ? {8'd0, gathered[7:0]} : gathered[15:0];
                            gathered >>= 16;
                        end
                        ST_FETCH:
                        begin
                            y.access_kind = KIND_FETCH;
                            y.access_address = pc;
                            gathered = (gathered << 16) + {16'd0, x.bus_data};
                            pc += 2;
                        end
                        ST_ABS: ea = gathered;
                        ST_SDISP: ea += {{16{gathered[15]}}, gathered[15:0]};
                        ST_INDEX:
                        begin
                            ri = gathered[14:12];
                            ea += {{24{gathered[7]}}, gathered[7:0]};
                            off = gathered[15] ? areg[ri] : dreg[ri];
                            if (!gathered[11])
                                off = {{16{off[15]}}, off[15:0]};
                            ea += off;
                        end
                        default: ;
                    endcase
                    left -= 1;
                    list_pos += 1;
                end
            end
            OP_BEGIN_RD: start_read(x.op_word);
            OP_BEGIN_MOD: start_modify(x);
            OP_WRITE_REG:
            begin
                if (x.register_select < 8)
                    dreg[x.register_select[2:0]] = x.value_in;
                else if (x.register_select < 16)
                    areg[x.register_select[2:0]] = x.value_in;
                else if (x.register_select == 16)
                    pc = x.value_in;
            end
            OP_READ_REG:
            begin
                if (x.register_select < 8)
                    y.register_value = dreg[x.register_select[2:0]];
                else if (x.register_select < 16)
                    y.register_value = areg[x.register_select[2:0]];
                else if (x.register_select == 16)
                    y.register_value = pc;
            end
            default: ;
        endcase
        if (left != 0)
        begin
            s = plan[list_no][list_pos];
            if (s == ST_READ)
            begin
                y.next_kind = rd_byte ? KIND_RD_BYTE : KIND_RD_WORD;
                y.next_address = ea;
            end
            else if (s == ST_WRITE)
            begin
                y.next_kind = wr_byte ? KIND_WR_BYTE : KIND_WR_WORD;
                y.next_address = ea - 2;
            end
            else if (s == ST_FETCH)
            begin
                y.next_kind = KIND_FETCH;
                y.next_address = pc;
            end
        end
        return y;
    endfunction

    function void note_input(input ea_in_t x);
        pending.push_back(predict_step(x));
    endfunction

    function void check_result(input ea_out_t y);
        ea_out_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result transfer");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (y.done_res !== e.done_res)
        begin
            $error("done_res: expected %0h, got %0h", e.done_res, y.done_res);
            errors++;
        end
        if (y.operand !== e.operand)
        begin
            $error("operand: expected %0h, got %0h", e.operand, y.operand);
            errors++;
        end
        if (y.access_kind !== e.access_kind)
        begin
            $error("access_kind: expected %0h, got %0h", e.access_kind, y.access_kind);
            errors++;
        end
        if (y.access_address !== e.access_address)
        begin
            $error("access_address: expected %0h, got %0h", e.access_address, y.access_address);
            errors++;
        end
        if (y.write_data !== e.write_data)
        begin
            $error("write_data: expected %0h, got %0h", e.write_data, y.write_data);
            errors++;
        end
        if (y.next_kind !== e.next_kind)
        begin
            $error("next_kind: expected %0h, got %0h", e.next_kind, y.next_kind);
            errors++;
        end
        if (y.next_address !== e.next_address)
        begin
            $error("next_address: expected %0h, got %0h", e.next_address, y.next_address);
            errors++;
        end
        if (y.register_value !== e.register_value)
        begin
            $error("register_value: expected %0h, got %0h", e.register_value, y.register_value);
            errors++;
        end
    endfunction
endclass

module tb_m68000_effective_address_sequencer_core;

    logic clk;
    logic rst_n;

    m68k_ea_stream_if #(.T(ea_in_t))  in_ch ();
    m68k_ea_stream_if #(.T(ea_out_t)) out_ch ();

    m68000_effective_address_sequencer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ea_scoreboard sb = new();

    // When set, both sides run without idle cycles.
    bit no_idle;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit hold_request;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Note every input transfer and check every result transfer. Values read here
    // at the edge are the ones from before it, so no ordering race arises.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
    end

    // Receiver: a random stall before each result, and a long hold-off on request.
    initial
    begin
        int wait_cycles;
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_request = 1'b0;
            end
            wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
            if (wait_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Offer one item after a random gap and hold it until it transfers.
    task automatic send_item(input ea_in_t x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= x;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    // Drop valid, let the last transfer be noted, then hold until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic ea_in_t random_item(input logic [2:0] opc);
        ea_in_t x;
        x.opcode          = opc;
        x.op_word         = 16'($urandom);
        x.value_in        = $urandom;
        x.register_select = 5'($urandom);
        x.bus_data        = 16'($urandom);
        x.extra_data_word = 2'($urandom);
        x.extra_data_long = 2'($urandom);
        x.extra_addr_word = 2'($urandom);
        x.extra_addr_long = 2'($urandom);
        return x;
    endfunction

    task automatic send_op(input logic [2:0] opc, input logic [15:0] op,
                           input logic [31:0] val, input logic [4:0] sel);
        ea_in_t x;
        x = random_item(opc);
        x.op_word = op;
        x.value_in = val;
        x.register_select = sel;
        send_item(x);
    endtask

    // One begin item followed by a run of steps with random bus data, now and then with a random
    // register or unused-opcode item between; the run may cover the whole sequence, stop short or overrun.
    task automatic send_sequence(input logic [2:0] opc, input logic [15:0] op, input int steps);
        ea_in_t x;
        x = random_item(opc);
        x.op_word = op;
        send_item(x);
        repeat (steps)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(random_item(3'($urandom_range(OP_WRITE_REG, 7))));
            send_item(random_item(OP_STEP));
        end
    endtask

    // Random operation word: mostly with a size field of byte, word or long (0 to 2),
    // else fully random.
    function automatic logic [15:0] random_op_word();
        logic [15:0] op;
        op = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            op[7:6] = 2'($urandom_range(0, 2));
        return op;
    endfunction

    initial
    begin
        int n;
        no_idle = 1'b0;
        hold_request = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: idle step, register extremes and unused selects, A7 byte
        // postincrement and predecrement, size 3, the modes that finish at once,
        // immediate modify and an unused opcode.
        send_op(OP_STEP, 16'h0000, 32'h0, 5'd0);
        send_op(OP_WRITE_REG, 16'h0000, 32'hffff_ffff, 5'd0);
        send_op(OP_WRITE_REG, 16'h0000, 32'h0000_1000, 5'd15);
        send_op(OP_WRITE_REG, 16'h0000, 32'h1234_5678, 5'd31);
        send_op(OP_READ_REG, 16'h0000, 32'h0, 5'd31);
        send_op(OP_READ_REG, 16'h0000, 32'h0, 5'd16);
        send_sequence(OP_BEGIN_RD, 16'h001f, 3);
        send_sequence(OP_BEGIN_RD, 16'h0027, 4);
        send_op(OP_READ_REG, 16'h0000, 32'h0, 5'd15);
        send_sequence(OP_BEGIN_RD, 16'h00d7, 2);
        send_sequence(OP_BEGIN_RD, 16'hffbf, 1);
        send_sequence(OP_BEGIN_MOD, 16'h00bd, 1);
        send_sequence(OP_BEGIN_MOD, 16'h007c, 1);
        send_op(3'd7, 16'hffff, 32'h0, 5'd0);

        // Random part: well-formed sequences for most of the run, with noise.
        for (n = 0; n < 190; n++)
        begin
            if (n == 40)
                no_idle = 1'b1;
            if (n == 60)
                no_idle = 1'b0;
            if (n == 80)
            begin
                // Keep offering items while the receiver holds off.
                no_idle = 1'b1;
                hold_request = 1'b1;
            end
            if (n == 95)
                no_idle = 1'b0;
            if (n == 120)
                drain();
            if ($urandom_range(0, 3) == 0)
                send_op(OP_WRITE_REG, 16'h0, ($urandom_range(0, 1) == 1) ? $urandom
                        : 32'($urandom_range(0, 255)), 5'($urandom_range(0, 16)));
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(3'($urandom)));
            else
                send_sequence(($urandom_range(0, 2) == 0) ? OP_BEGIN_MOD : OP_BEGIN_RD,
                              random_op_word(), $urandom_range(1, 10));
            if ($urandom_range(0, 4) == 0)
                send_op(OP_READ_REG, 16'h0, 32'h0, 5'($urandom));
        end

        drain();
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
design/m68k_ea_pkg.sv
design/m68k_ea_stream_if.sv
design/m68000_effective_address_sequencer_core.sv
bench/tb_m68000_effective_address_sequencer_core.sv
